FILE: rtl/ole_pkg.sv
package ole_pkg;

  // Default depth of the value store
  localparam int ENTRIES_DEF = 16;

  // Width of the size and position fields of a result
  localparam int RES_W = 11;

  // Width of a stored value
  localparam int VAL_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_INSERT     = 3'd2,
    CMD_SEARCH     = 3'd3,
    CMD_DELETE     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_UP,
    S_SEARCH,
    S_SHIFT_DN,
    S_DONE
  } state_t;

  // One finished result handed from the sequencer to the output register
  typedef struct packed {
    status_t           status;
    logic [RES_W-1:0]  found;
    logic              clamped;
    logic [RES_W-1:0]  size;
  } res_t;

endpackage

FILE: rtl/ordered_list_engine.sv
// ordered_list_engine: an ordered list of up to ENTRIES signed 32-bit values.
// Input channel (in_valid/in_ready) carries one command per transaction:
// push front, push back, insert at a 1-based position, search or delete,
// with in_value and in_position. Result channel (out_valid/out_ready)
// returns exactly one result per command: status, found_position,
// position_clamped and the list size after the command.
// Commands are handled one at a time by a sequencer that moves or compares
// one stored entry per cycle through a store with one write port and one
// registered read port. An insert moves the entries from its slot onward back
// one slot, from the last down, then writes the new value; a search walks
// from the front until a match or the end; a delete searches, then moves each
// later entry forward one slot. A full store or an unused code goes straight
// to the result. in_ready is high only while the sequencer is idle.
// A result sits in an output register; when the receiver stalls, the next
// command is still accepted and runs, then waits until the register frees.
// Reset empties the list and drops any pending result; store contents are
// not cleared, as only entries below the count are ever read.
module ordered_list_engine
  import ole_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [2:0]              in_command,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic [7:0]              in_position,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [RES_W-1:0]        out_found_position,
  output logic                    out_position_clamped,
  output logic [RES_W-1:0]        out_list_size
);

  localparam int AW = $clog2(ENTRIES);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [VAL_W-1:0] mem_rdata;

  logic             out_valid_r, out_valid_nxt;
  res_t             out_res_r;

  ole_seq #(
    .ENTRIES (ENTRIES)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (in_valid),
    .cmd_ready    (in_ready),
    .cmd_code     (in_command),
    .cmd_value    (in_value),
    .cmd_position (in_position),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata)
  );

  ole_store #(
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until the transaction completes
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_res_r.status;
  assign out_found_position   = out_res_r.found;
  assign out_position_clamped = out_res_r.clamped;
  assign out_list_size        = out_res_r.size;

endmodule

FILE: rtl/ole_store.sv
module ole_store
  import ole_pkg::*;
#(
  parameter int DEPTH = ENTRIES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [VAL_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [VAL_W-1:0] rdata
);

  logic [VAL_W-1:0] mem [DEPTH];
  logic [VAL_W-1:0] rdata_r;

  // Write one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ole_seq.sv
module ole_seq
  import ole_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // command side
  input  logic                    cmd_valid,
  output logic                    cmd_ready,
  input  logic [2:0]              cmd_code,
  input  logic signed [VAL_W-1:0] cmd_value,
  input  logic [7:0]              cmd_position,
  // result side
  output logic                    res_valid,
  input  logic                    res_ready,
  output res_t                    res,
  // store port
  output logic                    mem_we,
  output logic [$clog2(ENTRIES)-1:0] mem_waddr,
  output logic [VAL_W-1:0]        mem_wdata,
  output logic [$clog2(ENTRIES)-1:0] mem_raddr,
  input  logic [VAL_W-1:0]        mem_rdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  state_t           state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic [CW-1:0]    tgt_r, tgt_nxt;
  logic [CW-1:0]    dst_r, dst_nxt;
  logic             rv_r, rv_nxt;
  logic             del_r, del_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  status_t          st_r, st_nxt;
  logic [RES_W-1:0] found_r, found_nxt;
  logic             clamp_r, clamp_nxt;

  logic [PW-1:0]    pos_w;
  logic [PW-1:0]    pos_lim;
  logic [PW-1:0]    pos_sel;
  logic             pos_hi;
  logic             match;

  // Clamp the requested insert position into 1..count+1
  always_comb begin
    pos_w   = PW'(cmd_position);
    pos_lim = PW'(cnt_r) + PW'(1);
    pos_hi  = (pos_w > pos_lim);
    if (pos_hi) begin
      pos_sel = pos_lim;
    end else if (pos_w == '0) begin
      pos_sel = PW'(1);
    end else begin
      pos_sel = pos_w;
    end
  end

  // Shared compare of the value just read against the key
  assign match = rv_r && (mem_rdata == val_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    ptr_r   <= ptr_nxt;
    tgt_r   <= tgt_nxt;
    dst_r   <= dst_nxt;
    del_r   <= del_nxt;
    val_r   <= val_nxt;
    st_r    <= st_nxt;
    found_r <= found_nxt;
    clamp_r <= clamp_nxt;
  end

  // Next state and store access
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ptr_nxt   = ptr_r;
    tgt_nxt   = tgt_r;
    dst_nxt   = dst_r;
    rv_nxt    = 1'b0;
    del_nxt   = del_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    found_nxt = found_r;
    clamp_nxt = clamp_r;
    mem_we    = 1'b0;
    mem_waddr = tgt_r[AW-1:0];
    mem_wdata = val_r;
    mem_raddr = '0;
    cmd_ready = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          val_nxt   = cmd_value;
          st_nxt    = ST_OK;
          found_nxt = '0;
          clamp_nxt = 1'b0;
          del_nxt   = (cmd_t'(cmd_code) == CMD_DELETE);
          ptr_nxt   = '0;
          unique case (cmd_t'(cmd_code))
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
              if (cnt_r == FULL_CNT) begin
                st_nxt    = ST_FULL;
                state_nxt = S_DONE;
              end else begin
                if (cmd_t'(cmd_code) == CMD_PUSH_FRONT) begin
                  tgt_nxt = '0;
                end else if (cmd_t'(cmd_code) == CMD_PUSH_BACK) begin
                  tgt_nxt = cnt_r;
                end else begin
                  tgt_nxt   = CW'(pos_sel - PW'(1));
                  clamp_nxt = pos_hi;
                end
                found_nxt = RES_W'(tgt_nxt) + RES_W'(1);
                ptr_nxt   = cnt_r;
                state_nxt = S_SHIFT_UP;
              end
            end
            CMD_SEARCH, CMD_DELETE: begin
              state_nxt = S_SEARCH;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Move entries tgt..cnt-1 one slot back, then place the new value
      S_SHIFT_UP: begin
        if (rv_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (ptr_r > tgt_r) begin
          mem_raddr = AW'(ptr_r - CW'(1));
          rv_nxt    = 1'b1;
          dst_nxt   = ptr_r;
          ptr_nxt   = ptr_r - CW'(1);
        end else if (!rv_r) begin
          mem_we    = 1'b1;
          mem_waddr = tgt_r[AW-1:0];
          mem_wdata = val_r;
          cnt_nxt   = cnt_r + CW'(1);
          state_nxt = S_DONE;
        end
      end

      // Walk the store from the front, one entry per cycle
      S_SEARCH: begin
        if (match) begin
          tgt_nxt   = dst_r;
          found_nxt = RES_W'(dst_r) + RES_W'(1);
          if (del_r) begin
            ptr_nxt   = dst_r + CW'(1);
            state_nxt = S_SHIFT_DN;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (ptr_r < cnt_r) begin
          mem_raddr = ptr_r[AW-1:0];
          rv_nxt    = 1'b1;
          dst_nxt   = ptr_r;
          ptr_nxt   = ptr_r + CW'(1);
        end else if (!rv_r) begin
          st_nxt    = ST_NOT_FOUND;
          state_nxt = S_DONE;
        end
      end

      // Close the gap left by the removed entry
      S_SHIFT_DN: begin
        if (rv_r) begin
          mem_we    = 1'b1;
          mem_waddr = dst_r[AW-1:0];
          mem_wdata = mem_rdata;
        end
        if (ptr_r < cnt_r) begin
          mem_raddr = ptr_r[AW-1:0];
          rv_nxt    = 1'b1;
          dst_nxt   = ptr_r - CW'(1);
          ptr_nxt   = ptr_r + CW'(1);
        end else if (!rv_r) begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_DONE;
        end
      end

      // Hand the result over once the output register has room
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res.status  = st_r;
  assign res.found   = found_r;
  assign res.clamped = clamp_r;
  assign res.size    = RES_W'(cnt_r);

endmodule

FILE: rtl/ordered_list_engine_chk.sv
module ordered_list_engine_chk
  import ole_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              out_status,
  input logic [RES_W-1:0]        out_found_position,
  input logic                    out_position_clamped,
  input logic [RES_W-1:0]        out_list_size
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found_position) && $stable(out_position_clamped) &&
      $stable(out_list_size))
    else $error("result changed while stalled");

  // A refused insert leaves a full list and reports no position
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |->
      (out_list_size == RES_W'(ENTRIES)) && (out_found_position == '0) &&
      !out_position_clamped)
    else $error("full status with inconsistent fields");

  // A miss reports no position
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOT_FOUND) |->
      (out_found_position == '0) && !out_position_clamped)
    else $error("not found with a position");

  // A clamped insert lands at the back of the list
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_position_clamped |->
      (out_status == ST_OK) && (out_found_position == out_list_size))
    else $error("clamped insert not at the back");

  // Size never exceeds the store depth
  a_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_list_size <= RES_W'(ENTRIES)))
    else $error("list size above depth");

endmodule

bind ordered_list_engine ordered_list_engine_chk #(.ENTRIES(ENTRIES)) u_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_status           (out_status),
  .out_found_position   (out_found_position),
  .out_position_clamped (out_position_clamped),
  .out_list_size        (out_list_size)
);
